### rtl/gamepad_gesture_event_generator_assert.svh
// Assertion macros used by the gesture event generator checker.
// Depends on the including scope providing clk and arst_n.
`ifndef GAMEPAD_GESTURE_EVENT_GENERATOR_ASSERT_SVH
`define GAMEPAD_GESTURE_EVENT_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GGE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define GGE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gge_pkg.sv
// Types, codes and helper functions for the gamepad gesture event generator.
// Used by every module of the block; depends on nothing.
package gge_pkg;

	localparam int TIME_BITS = 32;
	localparam int LIM_BITS  = 16;
	localparam int NBTN      = 7;
	localparam int NTRK      = 3;

	localparam int T_CROSS  = 0;
	localparam int T_SELECT = 1;
	localparam int T_SQUARE = 2;

	localparam int B_L3       = 0;
	localparam int B_START    = 1;
	localparam int B_SELECT   = 2;
	localparam int B_TRIANGLE = 3;
	localparam int B_SQUARE   = 4;
	localparam int B_CIRCLE   = 5;
	localparam int B_CROSS    = 6;

	localparam logic [1:0] SLOT_ONE = 2'd1;
	localparam logic [1:0] SLOT_TWO = 2'd2;

	typedef enum logic [1:0] {
		ACT_FRAME     = 2'd0,
		ACT_RECONNECT = 2'd1,
		ACT_DISARM    = 2'd2,
		ACT_HOLD      = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_CROSS_LONG = 2'd0,
		CFG_LONG_PRESS = 2'd1,
		CFG_PAGE_GUARD = 2'd2,
		CFG_NEUTRAL    = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		EV_START       = 4'd0,
		EV_TRIANGLE    = 4'd1,
		EV_SQUARE      = 4'd2,
		EV_SQUARE_LONG = 4'd3,
		EV_CIRCLE      = 4'd4,
		EV_CROSS       = 4'd5,
		EV_CROSS_LONG  = 4'd6,
		EV_SELECT_LONG = 4'd7,
		EV_SLOT        = 4'd8
	} ev_kind_t;

	typedef struct packed {
		logic [LIM_BITS-1:0] cross_long_ms;
		logic [LIM_BITS-1:0] long_press_ms;
		logic [LIM_BITS-1:0] page_guard_ms;
		logic [1:0]          neutral_frames;
	} cfg_t;

	typedef struct packed {
		action_t              action;
		logic [TIME_BITS-1:0] now_ms;
		logic [NBTN-1:0]      btn;
		logic                 on_map_page;
		logic [1:0]           cur_slot;
		logic                 slot_locked;
	} item_t;

	typedef struct packed {
		logic [NBTN-1:0]                 prev_buttons;
		logic                            edges_ready;
		logic                            armed;
		logic [1:0]                      neutral_count;
		logic [TIME_BITS-1:0]            last_toggle_time;
		logic [NTRK-1:0]                 press_active;
		logic [NTRK-1:0]                 long_fired;
		logic [NTRK-1:0][TIME_BITS-1:0]  press_start_time;
	} state_t;

	typedef struct packed {
		logic     valid;
		ev_kind_t kind;
		logic [1:0] slot;
	} ev_t;

	typedef struct packed {
		ev_t  ev;
		logic page_toggle;
		logic slot_toggle;
	} res_t;

	function automatic logic [1:0] ev_rank(ev_kind_t k);
		logic [1:0] r;
		begin
			case (k)
				EV_CROSS_LONG: r = 2'd3;
				EV_CROSS:      r = 2'd2;
				EV_START:      r = 2'd1;
				default:       r = 2'd0;
			endcase
			return r;
		end
	endfunction

	function automatic ev_t ev_queue(ev_t cur, ev_kind_t k, logic [1:0] slot);
		ev_t r;
		begin
			r = cur;
			if (!cur.valid || (ev_rank(k) > ev_rank(cur.kind))) begin
				r.valid = 1'b1;
				r.kind  = k;
				r.slot  = slot;
			end
			return r;
		end
	endfunction

	function automatic state_t trk_clear(state_t s, int t);
		state_t r;
		begin
			r = s;
			r.press_active[t]     = 1'b0;
			r.long_fired[t]       = 1'b0;
			r.press_start_time[t] = '0;
			return r;
		end
	endfunction

	function automatic logic time_reached(logic [TIME_BITS-1:0] now,
			logic [TIME_BITS-1:0] then, logic [LIM_BITS-1:0] lim);
		logic [TIME_BITS-1:0] d;
		begin
			d = now - then;
			return d >= {{(TIME_BITS-LIM_BITS){1'b0}}, lim};
		end
	endfunction

endpackage

### rtl/gamepad_gesture_event_generator.sv
// Pipeline: input register item_s1, then result register res_s2; they decouple the two sides.
// Throughput: one frame per cycle while out_stall is low.
// The tracking state updates in the cycle that moves a frame from input to result register.
// Reset: arst_n clears valid flags and tracking state; item_s1 and res_s2 are not reset.
// Depends on gge_pkg, gge_cfg and gge_step.
module gamepad_gesture_event_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [1:0]                    cfg_index,
	input  logic [gge_pkg::LIM_BITS-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [gge_pkg::TIME_BITS-1:0] now_ms,
	input  logic                          btn_l3,
	input  logic                          btn_start,
	input  logic                          btn_select,
	input  logic                          btn_triangle,
	input  logic                          btn_square,
	input  logic                          btn_circle,
	input  logic                          btn_cross,
	input  logic                          on_map_page,
	input  logic [1:0]                    cur_slot,
	input  logic                          slot_locked,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          event_valid,
	output logic [3:0]                    event_kind,
	output logic [1:0]                    event_slot,
	output logic                          page_toggle,
	output logic                          slot_toggle
);

	gge_pkg::cfg_t   cfg;
	gge_pkg::item_t  item_in;
	gge_pkg::item_t  item_s1;
	logic            valid_s1;
	gge_pkg::state_t state_q;
	gge_pkg::state_t state_nxt;
	gge_pkg::res_t   res;
	gge_pkg::res_t   res_s2;
	logic            valid_s2;
	logic            advance;

	gge_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		item_in.action      = gge_pkg::action_t'(action);
		item_in.now_ms      = now_ms;
		item_in.btn         = {btn_cross, btn_circle, btn_square, btn_triangle,
			btn_select, btn_start, btn_l3};
		item_in.on_map_page = on_map_page;
		item_in.cur_slot    = cur_slot;
		item_in.slot_locked = slot_locked;
	end

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// capture beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item_in;
		end
	end

	gge_step u_step (
		.cfg    (cfg),
		.item   (item_s1),
		.st_cur (state_q),
		.st_nxt (state_nxt),
		.res    (res)
	);

	// advance tracking state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_nxt;
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign event_valid = res_s2.ev.valid;
	assign event_kind  = res_s2.ev.kind;
	assign event_slot  = res_s2.ev.slot;
	assign page_toggle = res_s2.page_toggle;
	assign slot_toggle = res_s2.slot_toggle;

endmodule

### rtl/gge_cfg.sv
// Configuration register file for the gesture event generator.
// Depends on gge_pkg.
module gge_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [1:0]                   cfg_index,
	input  logic [gge_pkg::LIM_BITS-1:0] cfg_data,
	output gge_pkg::cfg_t                cfg
);

	gge_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cross_long_ms  <= 16'd1200;
			cfg_q.long_press_ms  <= 16'd800;
			cfg_q.page_guard_ms  <= 16'd250;
			cfg_q.neutral_frames <= 2'd2;
		end else if (cfg_wr_en) begin
			unique case (gge_pkg::cfg_idx_t'(cfg_index))
				gge_pkg::CFG_CROSS_LONG: cfg_q.cross_long_ms  <= cfg_data;
				gge_pkg::CFG_LONG_PRESS: cfg_q.long_press_ms  <= cfg_data;
				gge_pkg::CFG_PAGE_GUARD: cfg_q.page_guard_ms  <= cfg_data;
				gge_pkg::CFG_NEUTRAL:    cfg_q.neutral_frames <= cfg_data[1:0];
				default:                 cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/gge_step.sv
// Per-frame gesture logic: edges, arming, long-press timers, event merge and reconnect, disarm and hold actions.
// Purely combinational; depends on gge_pkg.
module gge_step (
	input  gge_pkg::cfg_t   cfg,
	input  gge_pkg::item_t  item,
	input  gge_pkg::state_t st_cur,
	output gge_pkg::state_t st_nxt,
	output gge_pkg::res_t   res
);

	always_comb begin
		gge_pkg::state_t st;
		gge_pkg::ev_t    ev;
		logic            page_tg;
		logic            slot_tg;
		logic [1:0]      slot;
		logic [gge_pkg::NBTN-1:0] cur;
		logic [gge_pkg::NBTN-1:0] rise;
		logic [gge_pkg::NBTN-1:0] fall;
		logic            map;

		st      = st_cur;
		ev      = '0;
		page_tg = 1'b0;
		slot_tg = 1'b0;
		cur     = item.btn;
		map     = item.on_map_page;
		slot    = (item.cur_slot == gge_pkg::SLOT_TWO) ? gge_pkg::SLOT_TWO : gge_pkg::SLOT_ONE;
		rise    = cur & ~st_cur.prev_buttons;
		fall    = ~cur & st_cur.prev_buttons;

		unique case (item.action)
			gge_pkg::ACT_RECONNECT: begin
				st = '0;
			end
			gge_pkg::ACT_DISARM: begin
				st.armed = 1'b0;
				st.neutral_count = 2'd0;
				st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
				st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
				st = gge_pkg::trk_clear(st, gge_pkg::T_CROSS);
			end
			gge_pkg::ACT_HOLD: begin
				st.armed = 1'b0;
				st.neutral_count = 2'd0;
				st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
				st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
			end
			gge_pkg::ACT_FRAME: begin
				if (!st_cur.edges_ready) begin
					st.prev_buttons = cur;
					st.edges_ready = 1'b1;
					st.armed = 1'b0;
					st.neutral_count = 2'd0;
					st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
					st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
				end else begin
					// cross tracking runs regardless of arming
					if (rise[gge_pkg::B_CROSS] && map) begin
						st.press_active[gge_pkg::T_CROSS] = 1'b1;
						st.long_fired[gge_pkg::T_CROSS] = 1'b0;
						st.press_start_time[gge_pkg::T_CROSS] = item.now_ms;
						ev = gge_pkg::ev_queue(ev, gge_pkg::EV_CROSS, slot);
					end
					if (map && st.press_active[gge_pkg::T_CROSS] && cur[gge_pkg::B_CROSS] &&
							!st.long_fired[gge_pkg::T_CROSS] &&
							gge_pkg::time_reached(item.now_ms,
								st.press_start_time[gge_pkg::T_CROSS], cfg.cross_long_ms)) begin
						ev = gge_pkg::ev_queue(ev, gge_pkg::EV_CROSS_LONG, slot);
						st.long_fired[gge_pkg::T_CROSS] = 1'b1;
					end
					if (fall[gge_pkg::B_CROSS])
						st = gge_pkg::trk_clear(st, gge_pkg::T_CROSS);

					if (rise[gge_pkg::B_L3] || !map) begin
						if (rise[gge_pkg::B_L3] && ((st.last_toggle_time == '0) ||
								gge_pkg::time_reached(item.now_ms, st.last_toggle_time,
									cfg.page_guard_ms))) begin
							page_tg = 1'b1;
							st.last_toggle_time = item.now_ms;
						end
						st.armed = 1'b0;
						st.neutral_count = 2'd0;
						st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
						st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
						st = gge_pkg::trk_clear(st, gge_pkg::T_CROSS);
					end else if (!st.armed) begin
						if (cur == '0) begin
							if (st.neutral_count < cfg.neutral_frames)
								st.neutral_count = st.neutral_count + 2'd1;
							if (st.neutral_count >= cfg.neutral_frames) begin
								st.armed = 1'b1;
								st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
								st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
							end
						end else begin
							st.neutral_count = 2'd0;
						end
					end else begin
						if (rise[gge_pkg::B_START])
							ev = gge_pkg::ev_queue(ev, gge_pkg::EV_START, slot);

						if (rise[gge_pkg::B_SELECT]) begin
							st.press_active[gge_pkg::T_SELECT] = 1'b1;
							st.long_fired[gge_pkg::T_SELECT] = 1'b0;
							st.press_start_time[gge_pkg::T_SELECT] = item.now_ms;
						end
						if (st.press_active[gge_pkg::T_SELECT] && cur[gge_pkg::B_SELECT] &&
								!st.long_fired[gge_pkg::T_SELECT] &&
								gge_pkg::time_reached(item.now_ms,
									st.press_start_time[gge_pkg::T_SELECT],
									cfg.long_press_ms)) begin
							ev = gge_pkg::ev_queue(ev, gge_pkg::EV_SELECT_LONG, slot);
							st.long_fired[gge_pkg::T_SELECT] = 1'b1;
						end
						if (fall[gge_pkg::B_SELECT] && st.press_active[gge_pkg::T_SELECT]) begin
							if (!st.long_fired[gge_pkg::T_SELECT] && !item.slot_locked) begin
								slot_tg = 1'b1;
								slot = (slot == gge_pkg::SLOT_TWO) ? gge_pkg::SLOT_ONE
									: gge_pkg::SLOT_TWO;
								ev = gge_pkg::ev_queue(ev, gge_pkg::EV_SLOT, slot);
							end
							st = gge_pkg::trk_clear(st, gge_pkg::T_SELECT);
						end

						if (rise[gge_pkg::B_SQUARE]) begin
							st.press_active[gge_pkg::T_SQUARE] = 1'b1;
							st.long_fired[gge_pkg::T_SQUARE] = 1'b0;
							st.press_start_time[gge_pkg::T_SQUARE] = item.now_ms;
						end
						if (st.press_active[gge_pkg::T_SQUARE] && cur[gge_pkg::B_SQUARE] &&
								!st.long_fired[gge_pkg::T_SQUARE] &&
								gge_pkg::time_reached(item.now_ms,
									st.press_start_time[gge_pkg::T_SQUARE],
									cfg.long_press_ms)) begin
							ev = gge_pkg::ev_queue(ev, gge_pkg::EV_SQUARE_LONG, slot);
							st.long_fired[gge_pkg::T_SQUARE] = 1'b1;
						end
						if (fall[gge_pkg::B_SQUARE] && st.press_active[gge_pkg::T_SQUARE]) begin
							if (!st.long_fired[gge_pkg::T_SQUARE])
								ev = gge_pkg::ev_queue(ev, gge_pkg::EV_SQUARE, slot);
							st = gge_pkg::trk_clear(st, gge_pkg::T_SQUARE);
						end

						if (rise[gge_pkg::B_TRIANGLE])
							ev = gge_pkg::ev_queue(ev, gge_pkg::EV_TRIANGLE, slot);
						if (rise[gge_pkg::B_CIRCLE])
							ev = gge_pkg::ev_queue(ev, gge_pkg::EV_CIRCLE, slot);
					end
					st.prev_buttons = cur;
				end
			end
			default: st = st_cur;
		endcase

		st_nxt          = st;
		res.ev          = ev;
		res.page_toggle = page_tg;
		res.slot_toggle = slot_tg;
	end

endmodule

### rtl/gge_checker.sv
// Port-level checker for the gesture event generator, bound to the top level.
// Depends on gge_pkg and gamepad_gesture_event_generator_assert.svh.
`include "gamepad_gesture_event_generator_assert.svh"

module gge_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       event_valid,
	input logic [3:0] event_kind,
	input logic [1:0] event_slot,
	input logic       page_toggle,
	input logic       slot_toggle
);

	`GGE_ASSERT_IMP(a_no_event_zero, out_valid && !event_valid, (event_kind == 4'd0) && (event_slot == 2'd0), "empty beat carries a kind or slot")

	`GGE_ASSERT_IMP(a_event_fields, out_valid && event_valid, (event_kind <= gge_pkg::EV_SLOT) && ((event_slot == gge_pkg::SLOT_ONE) || (event_slot == gge_pkg::SLOT_TWO)), "event beat with bad kind or slot")

	`GGE_ASSERT_IMP(a_slot_toggle_event, out_valid && slot_toggle, event_valid && !page_toggle && ((event_kind == gge_pkg::EV_SLOT) || (event_kind == gge_pkg::EV_START) || (event_kind == gge_pkg::EV_CROSS) || (event_kind == gge_pkg::EV_CROSS_LONG)), "slot toggle without matching event")

	`GGE_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(event_valid) && $stable(event_kind) && $stable(event_slot) && $stable(page_toggle) && $stable(slot_toggle), "stalled result beat changed")

endmodule

bind gamepad_gesture_event_generator gge_checker u_gge_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.event_valid (event_valid),
	.event_kind  (event_kind),
	.event_slot  (event_slot),
	.page_toggle (page_toggle),
	.slot_toggle (slot_toggle)
);
